[hw/rtl/pprob_pkg.sv]
// ----------------------------------------------------------------------------
// pprob_pkg
// Shared constants, types and helpers of the ping-pong ring output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package pprob_pkg;

  // Ring depth of one page, 2 to 64 bytes
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned ADDR_W = $clog2(2 * DEPTH);

  // Input actions
  localparam logic ACT_PUT   = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic put;    // store in_byte at the write page head
    logic issue;  // start one read-page result
    logic swap;   // exchange read and write pages
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic empty;      // read page has head equal to tail
    logic last;       // the byte at the tail is the final one of the run
    logic can_issue;  // result queue has room for one more item
  } status_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
  } result_t;

  // Advance a ring index with wrap at DEPTH-1
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    if (idx == IDX_W'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + IDX_W'(1);
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pprob_if.sv]
// ----------------------------------------------------------------------------
// pprob_in_if / pprob_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pprob_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] in_byte;

  modport source (output valid, output action, output in_byte, input ready);
  modport sink   (input valid, input action, input in_byte, output ready);
endinterface

interface pprob_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last_of_run;

  modport source (output valid, output out_byte, output byte_valid,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

[hw/rtl/ping_pong_ring_output_buffer_unit.sv]
// ----------------------------------------------------------------------------
// ping_pong_ring_output_buffer_unit
// Two byte rings used as write and read pages; a flush drains the read page
// as a marked run and swaps the pages.
// Timing: a put is stored in the cycle it is accepted; the first result of a
//   flush passes the controller state, the read stage and the result queue.
// Throughput: one put per cycle while idle; a flush holds off input until its
//   run is fully issued, at one page-store read per cycle while the result
//   queue has room, so output stalls stretch this.
// Reset: all heads, tails and the page select clear to zero; page contents
//   are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module ping_pong_ring_output_buffer_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  pprob_in_if.sink     in_i,
  pprob_out_if.source  out_o
);
  import pprob_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t res;

  pprob_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pprob_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_byte_i   (in_i.in_byte),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_res_o   (res)
  );

  assign out_o.out_byte    = res.out_byte;
  assign out_o.byte_valid  = res.byte_valid;
  assign out_o.last_of_run = res.last_of_run;

endmodule

`default_nettype wire

[hw/rtl/pprob_ctrl.sv]
// ----------------------------------------------------------------------------
// pprob_ctrl
// Controller: takes puts while idle, sequences a flush run one item at a time
// and swaps pages when the run is fully issued.
// ----------------------------------------------------------------------------
`default_nettype none

module pprob_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_action_i,
  output logic              in_ready_o,
  input  pprob_pkg::status_t status_i,
  output pprob_pkg::cmd_t    cmd_o
);
  import pprob_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_action_i == ACT_FLUSH)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.can_issue && (status_i.empty || status_i.last)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.put  = in_valid_i && (in_action_i == ACT_PUT);
      end
      ST_DRAIN: begin
        cmd_o.issue = status_i.can_issue;
        cmd_o.swap  = status_i.can_issue && (status_i.empty || status_i.last);
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/pprob_dp.sv]
// ----------------------------------------------------------------------------
// pprob_dp
// Datapath: page store, per-page head and tail indices, read stage and a
// two-entry result queue that feeds the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pprob_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pprob_pkg::cmd_t     cmd_i,
  output pprob_pkg::status_t  status_o,
  input  logic [7:0]          in_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pprob_pkg::result_t  out_res_o
);
  import pprob_pkg::*;

  // Page store
  logic [7:0] mem_q [2*DEPTH];
  logic [7:0] rdata_q;

  // Ring indices per page and page role
  logic [1:0][IDX_W-1:0] head_q, head_d;
  logic [1:0][IDX_W-1:0] tail_q, tail_d;
  logic                  read_page_q, read_page_d;
  logic                  write_page;

  logic [IDX_W-1:0]  rd_head, rd_tail, wr_head, tail_nxt;
  logic [ADDR_W-1:0] waddr, raddr;

  // Read stage
  logic rd_vld_q, rd_byte_q, rd_last_q;

  // Result queue
  result_t    q_mem_q [2];
  logic       q_wptr_q, q_rptr_q;
  logic [1:0] q_cnt_q, q_cnt_d;
  logic [1:0] used;
  logic       push, pop;
  result_t    push_res;

  assign write_page = ~read_page_q;
  assign rd_head    = read_page_q ? head_q[1] : head_q[0];
  assign rd_tail    = read_page_q ? tail_q[1] : tail_q[0];
  assign wr_head    = write_page  ? head_q[1] : head_q[0];
  assign tail_nxt   = ring_next(rd_tail);

  assign waddr = (write_page  ? ADDR_W'(DEPTH) : '0) + ADDR_W'(wr_head);
  assign raddr = (read_page_q ? ADDR_W'(DEPTH) : '0) + ADDR_W'(rd_tail);

  // Status toward the controller
  assign pop                = out_valid_o && out_ready_i;
  assign used               = q_cnt_q + {1'b0, rd_vld_q};
  assign status_o.empty     = (rd_head == rd_tail);
  assign status_o.last      = (tail_nxt == rd_head);
  assign status_o.can_issue = pop ? (used <= 2'd2) : (used <= 2'd1);

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.put) begin
      mem_q[waddr] <= in_byte_i;
    end
    if (cmd_i.issue) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Advance indices and swap pages
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    read_page_d = read_page_q;
    if (cmd_i.put) begin
      head_d[write_page] = ring_next(wr_head);
    end
    if (cmd_i.issue && !status_o.empty) begin
      tail_d[read_page_q] = tail_nxt;
    end
    if (cmd_i.swap) begin
      read_page_d = ~read_page_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      read_page_q <= 1'b0;
      rd_vld_q    <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      read_page_q <= read_page_d;
      rd_vld_q    <= cmd_i.issue;
    end
  end

  // Read stage flags
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_byte_q <= ~status_o.empty;
      rd_last_q <= status_o.empty | status_o.last;
    end
  end

  // Form the result; an empty flush carries a zero byte
  assign push                 = rd_vld_q;
  assign push_res.out_byte    = rd_byte_q ? rdata_q : 8'h00;
  assign push_res.byte_valid  = rd_byte_q;
  assign push_res.last_of_run = rd_last_q;

  // Result queue
  always_comb begin
    q_cnt_d = q_cnt_q;
    if (push && !pop) begin
      q_cnt_d = q_cnt_q + 2'd1;
    end else if (!push && pop) begin
      q_cnt_d = q_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q  <= '0;
      q_wptr_q <= 1'b0;
      q_rptr_q <= 1'b0;
    end else begin
      q_cnt_q <= q_cnt_d;
      if (push) begin
        q_wptr_q <= ~q_wptr_q;
      end
      if (pop) begin
        q_rptr_q <= ~q_rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[q_wptr_q] <= push_res;
    end
  end

  assign out_valid_o = (q_cnt_q != 2'd0);
  assign out_res_o   = q_mem_q[q_rptr_q];

endmodule

`default_nettype wire

[hw/rtl/pprob_checker.sv]
// ----------------------------------------------------------------------------
// pprob_checker
// Port-level checks of the ping-pong ring output buffer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pprob_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_action_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       byte_valid_i,
  input logic       last_of_run_i
);
  import pprob_pkg::*;

  // A stalled item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // An empty flush gives a zero byte that closes its run
  a_empty_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_valid_i |-> last_of_run_i && (out_byte_i == 8'h00))
    else $error("empty flush result malformed");

  // Accepting a flush holds off input in the next cycle
  a_flush_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i == ACT_FLUSH) |=> !in_ready_i)
    else $error("input taken during flush run");

  // No result leaves right after reset without a flush
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result item without flush");

endmodule

bind ping_pong_ring_output_buffer_unit pprob_checker u_pprob_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_action_i   (in_i.action),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .byte_valid_i  (out_o.byte_valid),
  .last_of_run_i (out_o.last_of_run)
);

`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ping-pong ring output buffer. A short directed
// table runs first. Random put bursts, each closed by a flush, follow. Every
// drained result is compared in order against the row's own result or a model
// of the two pages kept inside the bench.
// ----------------------------------------------------------------------------
module tb;
  import pprob_pkg::*;

  localparam int unsigned RND_ITEMS   = 160;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned MAX_PRINTS  = 100;
  localparam int unsigned DIR_ROWS    = 22;

  localparam result_t EMPTY_RUN = '{8'h00, 1'b0, 1'b1};

  typedef enum int {
    PH_FREE,
    PH_SRC_IDLE,
    PH_BACKPRESSURE,
    PH_SINK_STALL,
    PH_BOTH
  } phase_e;

  typedef struct packed {
    logic       act;
    logic [7:0] data;
    logic       fixed;  // the row gives the single drain result itself
    result_t    want;
  } dir_row_t;

  // Page roles after reset: page 0 is read, page 1 is written
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ACT_FLUSH, 8'h00, 1'b1, EMPTY_RUN},               // page 0 empty
    '{ACT_FLUSH, 8'hFF, 1'b1, EMPTY_RUN},               // page 1 empty
    '{ACT_PUT,   8'h00, 1'b0, '0},
    '{ACT_FLUSH, 8'h00, 1'b1, EMPTY_RUN},               // page 0 still empty
    '{ACT_FLUSH, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1}},    // single zero byte
    '{ACT_PUT,   8'hFF, 1'b0, '0},
    '{ACT_PUT,   8'hA5, 1'b0, '0},
    '{ACT_PUT,   8'h5A, 1'b0, '0},
    '{ACT_PUT,   8'h80, 1'b0, '0},
    '{ACT_FLUSH, 8'hFF, 1'b1, EMPTY_RUN},
    '{ACT_PUT,   8'h01, 1'b0, '0},
    '{ACT_PUT,   8'h7F, 1'b0, '0},
    '{ACT_FLUSH, 8'h00, 1'b0, '0},                      // four-byte run
    '{ACT_FLUSH, 8'hFF, 1'b0, '0},                      // two-byte run
    '{ACT_FLUSH, 8'h00, 1'b1, EMPTY_RUN},               // drained page, head kept
    '{ACT_PUT,   8'hFE, 1'b0, '0},
    '{ACT_FLUSH, 8'h00, 1'b1, EMPTY_RUN},
    '{ACT_FLUSH, 8'h00, 1'b1, '{8'hFE, 1'b1, 1'b1}},
    '{ACT_PUT,   8'h55, 1'b0, '0},
    '{ACT_PUT,   8'hAA, 1'b0, '0},
    '{ACT_FLUSH, 8'hFF, 1'b1, EMPTY_RUN},
    '{ACT_FLUSH, 8'h00, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  pprob_in_if  in_if ();
  pprob_out_if out_if ();

  ping_pong_ring_output_buffer_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Page model: byte store, per-page head and tail, read page select
  logic [7:0]       pg_store [2*DEPTH];
  logic [IDX_W-1:0] pg_head  [2];
  logic [IDX_W-1:0] pg_tail  [2];
  logic             pg_rd_sel;

  // Drain results still owed by the block, oldest first
  result_t drained_q [$];

  phase_e      phase   = PH_FREE;
  int unsigned err_cnt = 0;
  int unsigned rnd_cnt = 0;

  // Toggle the clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
  endtask

  // Apply one item to the page model; queue its drain results if asked
  task automatic model_pages(input logic act, input logic [7:0] data, input bit queue_it);
    logic    wp;
    logic    rp;
    result_t res;
    if (act == ACT_PUT) begin
      wp = ~pg_rd_sel;
      pg_store[int'(wp) * DEPTH + int'(pg_head[wp])] = data;
      pg_head[wp] = IDX_W'((int'(pg_head[wp]) + 1) % DEPTH);
    end else begin
      rp = pg_rd_sel;
      if (pg_head[rp] == pg_tail[rp]) begin
        if (queue_it) drained_q.push_back(EMPTY_RUN);
      end else begin
        while (pg_tail[rp] != pg_head[rp]) begin
          res.out_byte   = pg_store[int'(rp) * DEPTH + int'(pg_tail[rp])];
          res.byte_valid = 1'b1;
          pg_tail[rp]    = IDX_W'((int'(pg_tail[rp]) + 1) % DEPTH);
          res.last_of_run = (pg_tail[rp] == pg_head[rp]);
          if (queue_it) drained_q.push_back(res);
        end
      end
      pg_rd_sel = ~rp;
    end
  endtask

  function automatic bit src_gap();
    case (phase)
      PH_SRC_IDLE: return $urandom_range(0, 99) < 85;
      PH_BOTH:     return $urandom_range(0, 99) < 13;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit sink_stall();
    case (phase)
      PH_SINK_STALL: return $urandom_range(0, 99) < 85;
      PH_BOTH:       return $urandom_range(0, 99) < 13;
      default:       return 1'b0;
    endcase
  endfunction

  // Offer one item, with random gaps ahead of it, and hold until accepted
  task automatic send_item(input logic act, input logic [7:0] data);
    while (src_gap()) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.action  <= act;
    in_if.in_byte <= data;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic send_random(input logic act, input logic [7:0] data);
    phase = (rnd_cnt * 5 / RND_ITEMS > 4) ? PH_BOTH : phase_e'(rnd_cnt * 5 / RND_ITEMS);
    send_item(act, data);
    model_pages(act, data, 1'b1);
    rnd_cnt++;
  endtask

  // Stimulus and end of run
  initial begin
    int unsigned n_put;
    int unsigned pick;
    int unsigned seg;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.action  <= ACT_PUT;
    in_if.in_byte <= '0;
    pg_head[0]    = '0;
    pg_head[1]    = '0;
    pg_tail[0]    = '0;
    pg_tail[1]    = '0;
    pg_rd_sel     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_item(dir_tab[r].act, dir_tab[r].data);
      if (dir_tab[r].fixed) drained_q.push_back(dir_tab[r].want);
      model_pages(dir_tab[r].act, dir_tab[r].data, !dir_tab[r].fixed);
    end

    // Random put bursts, each closed by a flush; one fills a page to the
    // longest run, one wraps a page all the way round so it looks empty
    seg = 0;
    while (rnd_cnt < RND_ITEMS) begin
      if (seg == 2) begin
        n_put = DEPTH - 1;
      end else if (seg == 5) begin
        n_put = DEPTH;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          n_put = $urandom_range(DEPTH - 2, DEPTH + 2);
        end else if (pick < 25) begin
          n_put = $urandom_range(7, 20);
        end else begin
          n_put = $urandom_range(0, 6);
        end
      end
      repeat (n_put) send_random(ACT_PUT, 8'($urandom_range(0, 255)));
      send_random(ACT_FLUSH, 8'($urandom_range(0, 255)));
      seg++;
    end
    in_if.valid <= 1'b0;

    // Drain what is owed, then let the block settle
    while (drained_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: check accepted items, then drive ready
  initial begin
    result_t     want;
    int unsigned hold;
    phase_e      seen;
    hold = 0;
    seen = PH_FREE;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        if (drained_q.size() == 0) begin
          report($sformatf("unexpected result byte %02h valid %0b last %0b",
                           out_if.out_byte, out_if.byte_valid, out_if.last_of_run));
        end else begin
          want = drained_q.pop_front();
          if (out_if.out_byte !== want.out_byte) begin
            report($sformatf("out_byte %02h, expected %02h", out_if.out_byte, want.out_byte));
          end
          if (out_if.byte_valid !== want.byte_valid) begin
            report($sformatf("byte_valid %0b, expected %0b",
                             out_if.byte_valid, want.byte_valid));
          end
          if (out_if.last_of_run !== want.last_of_run) begin
            report($sformatf("last_of_run %0b, expected %0b",
                             out_if.last_of_run, want.last_of_run));
          end
        end
      end
      // Hold off for a long stretch when back-pressure starts
      if (phase == PH_BACKPRESSURE && seen != PH_BACKPRESSURE) begin
        hold = HOLD_CYCLES;
      end
      seen = phase;
      if (hold != 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !sink_stall();
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    int unsigned quiet_cyc;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cyc = 0;
    end else begin
      quiet_cyc++;
    end
    if (quiet_cyc >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule

[sim.f]
hw/rtl/pprob_pkg.sv
hw/rtl/pprob_if.sv
hw/rtl/pprob_ctrl.sv
hw/rtl/pprob_dp.sv
hw/rtl/ping_pong_ring_output_buffer_unit.sv
hw/rtl/pprob_checker.sv
sim/tb.sv
